### sv/ppsch_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Shared widths, command and status codes, and the scan token that moves
// along the row of process cells.
// ----------------------------------------------------------------------------
package ppsch_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int TIME_W     = 16;
  localparam int PRI_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_RAN      = 3'd2,
    ST_IDLE     = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  // Best candidate found so far during a scan. The slot number travels
  // beside it because its width follows the table depth.
  typedef struct packed {
    logic              vld;
    logic              found;
    logic              any_left;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] rem;
  } tok_t;

endpackage

### sv/ppsch_cell.sv
// ----------------------------------------------------------------------------
// Process cell
// Holds one table entry and compares it against the scan token passing by,
// handing the winner on to the next cell through a register.
// ----------------------------------------------------------------------------
module ppsch_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          used,
  input  logic [ppsch_pkg::TIME_W-1:0]  now,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_slot,
  input  logic [ppsch_pkg::TIME_W-1:0]  wr_arr,
  input  logic [ppsch_pkg::TIME_W-1:0]  wr_rem,
  input  logic [ppsch_pkg::PRI_W-1:0]   wr_pri,
  input  logic                          dec_en,
  input  logic [IDX_W-1:0]              dec_slot,
  input  ppsch_pkg::tok_t               tok_in,
  input  logic [IDX_W-1:0]              slot_in,
  output ppsch_pkg::tok_t               tok_out,
  output logic [IDX_W-1:0]              slot_out
);
  import ppsch_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [TIME_W-1:0] arr_r;
  logic [TIME_W-1:0] rem_r;
  logic [PRI_W-1:0]  pri_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              vld_r;
  logic [IDX_W-1:0]  slot_r;
  logic [IDX_W-1:0]  slot_nxt;
  logic              live;
  logic              eligible;
  logic              take;

  assign live     = used && (rem_r != '0);
  assign eligible = live && (arr_r <= now);
  // Strict compares keep the lower slot on an exact tie.
  assign take     = eligible && (!tok_in.found || (pri_r > tok_in.pri) ||
                    ((pri_r == tok_in.pri) && (arr_r < tok_in.arr)));

  always_comb begin
    tok_nxt          = tok_in;
    tok_nxt.found    = tok_in.found | eligible;
    tok_nxt.any_left = tok_in.any_left | live;
    slot_nxt         = slot_in;
    if (take) begin
      tok_nxt.pri = pri_r;
      tok_nxt.arr = arr_r;
      tok_nxt.rem = rem_r;
      slot_nxt    = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == MY_IDX)) begin
      arr_r <= wr_arr;
      rem_r <= wr_rem;
      pri_r <= wr_pri;
    end else if (dec_en && (dec_slot == MY_IDX)) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in.vld;
    end
  end

  always_comb begin
    tok_out     = tok_r;
    tok_out.vld = vld_r;
  end

  assign slot_out = slot_r;

endmodule

### sv/preemptive_priority_scheduler.sv
// Requests are handled one at a time: in_stall stays high from the accepting
// edge until the result has moved into the output register. A tick's result
// waits for the scan token walking the row of cells one cell per cycle, while
// a load's result goes straight to the result register. Output stalls hold
// the result and delay the next request.
// Reset (synchronous, active low) clears the process count, the time counter
// and all handshake state; table entries stay undefined until loaded.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// A row of process cells holds the table. A tick sends a scan token through
// the row; it leaves the last cell carrying the best eligible process, which
// is then run for one time unit.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = ppsch_pkg::MAX_PROCS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [ppsch_pkg::TIME_W-1:0]      in_arrival_time,
  input  logic [ppsch_pkg::TIME_W-1:0]      in_burst_time,
  input  logic [ppsch_pkg::PRI_W-1:0]       in_priority_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ppsch_pkg::STATUS_W-1:0]    out_status,
  output logic [ppsch_pkg::SLOT_OUT_W-1:0]  out_slot,
  output logic                              out_completed,
  output logic [ppsch_pkg::TIME_W-1:0]      out_tick_time
);
  import ppsch_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  // The controller waits for a request, walks a scan through the cells for
  // a tick, then holds the finished result until the output register frees.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        loaded_count_r, loaded_count_nxt;
  logic [TIME_W-1:0]       time_now_r, time_now_nxt;

  // Result waiting to enter the output register.
  status_t                 res_status_r, res_status_nxt;
  logic [SLOT_OUT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                    res_completed_r, res_completed_nxt;
  logic [TIME_W-1:0]       res_time_r, res_time_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  logic                    out_completed_r;
  logic [TIME_W-1:0]       out_tick_time_r;

  logic                    accept;
  logic                    table_full;
  logic                    wr_en;
  logic                    scan_done;
  logic                    dec_en;
  logic                    out_load;
  logic [TIME_W-1:0]       time_adv;

  tok_t                    chain [MAX_PROCS+1];
  logic [IDX_W-1:0]        slot_chain [MAX_PROCS+1];
  logic [MAX_PROCS-1:0]    tok_vld_vec;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign table_full = (loaded_count_r == CNT_W'(MAX_PROCS));
  assign wr_en      = accept && (in_cmd == CMD_LOAD) && !table_full;

  // A tick request injects a fresh token straight into the first cell.
  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = accept && (in_cmd == CMD_TICK);
    slot_chain[0]     = '0;
  end

  // The table is the row of cells. Cell i takes part only once it has been
  // loaded, that is while i is below the process count.
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    logic used;
    assign used = (CNT_W'(i) < loaded_count_r);

    ppsch_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .used     (used),
      .now      (time_now_r),
      .wr_en    (wr_en),
      .wr_slot  (loaded_count_r[IDX_W-1:0]),
      .wr_arr   (in_arrival_time),
      .wr_rem   (in_burst_time),
      .wr_pri   (in_priority_req),
      .dec_en   (dec_en),
      .dec_slot (slot_chain[MAX_PROCS]),
      .tok_in   (chain[i]),
      .slot_in  (slot_chain[i]),
      .tok_out  (chain[i+1]),
      .slot_out (slot_chain[i+1])
    );

    assign tok_vld_vec[i] = chain[i+1].vld;
  end

  // When the token leaves the last cell it carries the winner, if any, and
  // whether any loaded process still has work left. The winner's remaining
  // time is decremented at that same edge.
  assign scan_done = (state_r == S_SCAN) && chain[MAX_PROCS].vld;
  assign dec_en    = scan_done && chain[MAX_PROCS].found;
  assign time_adv  = (time_now_r != TIME_MAX) ? (time_now_r + 1'b1) : time_now_r;

  // The finished result moves on whenever the output register is empty or
  // is being read in this cycle.
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt         = state_r;
    loaded_count_nxt  = loaded_count_r;
    time_now_nxt      = time_now_r;
    res_status_nxt    = res_status_r;
    res_slot_nxt      = res_slot_r;
    res_completed_nxt = res_completed_r;
    res_time_nxt      = res_time_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD) begin
            res_completed_nxt = 1'b0;
            res_time_nxt      = '0;
            if (table_full) begin
              res_status_nxt = ST_FULL;
              res_slot_nxt   = '0;
            end else begin
              res_status_nxt   = ST_LOADED;
              res_slot_nxt     = SLOT_OUT_W'(loaded_count_r[IDX_W-1:0]);
              loaded_count_nxt = loaded_count_r + 1'b1;
            end
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          res_time_nxt = time_now_r;
          if (!chain[MAX_PROCS].any_left) begin
            // Every loaded process is done: time holds.
            res_status_nxt    = ST_FINISHED;
            res_slot_nxt      = '0;
            res_completed_nxt = 1'b0;
          end else if (!chain[MAX_PROCS].found) begin
            // Work remains but nothing has arrived yet.
            res_status_nxt    = ST_IDLE;
            res_slot_nxt      = '0;
            res_completed_nxt = 1'b0;
            time_now_nxt      = time_adv;
          end else begin
            res_status_nxt    = ST_RAN;
            res_slot_nxt      = SLOT_OUT_W'(slot_chain[MAX_PROCS]);
            res_completed_nxt = (chain[MAX_PROCS].rem == TIME_W'(1));
            time_now_nxt      = time_adv;
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      loaded_count_r <= '0;
      time_now_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      loaded_count_r <= loaded_count_nxt;
      time_now_r     <= time_now_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r    <= res_status_nxt;
    res_slot_r      <= res_slot_nxt;
    res_completed_r <= res_completed_nxt;
    res_time_r      <= res_time_nxt;
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_slot_r      <= res_slot_r;
      out_completed_r <= res_completed_r;
      out_tick_time_r <= res_time_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_completed = out_completed_r;
  assign out_tick_time = out_tick_time_r;

`ifndef ASSERT_OFF
  // Only one scan may be in flight in the row of cells.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one scan token in the cell row");

  // A token reaches the end of the row only while a scan is running.
  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_PROCS].vld |-> (state_r == S_SCAN))
    else $error("scan token left the row outside a scan");

  // The process count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_count_r <= CNT_W'(MAX_PROCS))
    else $error("process count beyond table depth");

  // Time never runs backward.
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (time_now_r >= $past(time_now_r)))
    else $error("time counter went backward");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load and tick requests into the scheduler and checks every result
// against its expected value, typed in or taken from an in-bench scheduling
// predictor. A short directed table comes first, then random traffic.
// ----------------------------------------------------------------------------
module tb;

  import ppsch_pkg::*;

  localparam int NPROC = MAX_PROCS_DEF;

  // Number of random requests after the directed table.
  localparam int RANDOM_REQUESTS = 1700;

  // The random part runs with no idling on either side over this window of
  // request indexes.
  localparam int QUIET_FROM = 700;
  localparam int QUIET_TO   = 1000;

  // One request as it goes onto the input channel.
  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRI_W-1:0]  prio;
  } sched_req_t;

  // One result as it comes off the output channel.
  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  completed;
    logic [TIME_W-1:0]     tick_time;
  } sched_result_t;

  // One row of the directed table. When known is set, the expected result is
  // the one typed into the row; otherwise it comes from the predictor.
  typedef struct packed {
    sched_req_t    req;
    logic          known;
    sched_result_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [TIME_W-1:0]     in_arrival_time;
  logic [TIME_W-1:0]     in_burst_time;
  logic [PRI_W-1:0]      in_priority_req;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_completed;
  logic [TIME_W-1:0]     out_tick_time;

  preemptive_priority_scheduler u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_arrival_time (in_arrival_time),
    .in_burst_time   (in_burst_time),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_completed   (out_completed),
    .out_tick_time   (out_tick_time)
  );

  // Predicted copy of the process table and the time counter. Only slots
  // below table_fill are ever looked at.
  logic [TIME_W-1:0] tbl_arrival [NPROC];
  logic [PRI_W-1:0]  tbl_prio    [NPROC];
  logic [TIME_W-1:0] tbl_left    [NPROC];
  int                table_fill;
  logic [TIME_W-1:0] clock_units;

  // Results still owed by the scheduler, oldest first.
  sched_result_t awaited_outcomes [$];
  sched_result_t head;

  plan_row_t directed_plan [$];

  bit quiet;
  int mismatch_count = 0;

  // Tallies of what the run went through, taken from the predictor.
  int n_loaded, n_rejected, n_ran, n_idle, n_finished, n_completed;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run as a failure if it has not finished by then.
  initial begin
    #(4_000_000);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scheduling predictor
  // --------------------------------------------------------------------------
  // Applies one accepted request to the predicted table and returns the
  // result it must produce. A load appends to the next free slot or is
  // turned away on a full table. A tick picks, among processes that have
  // arrived and still have work, the highest priority, then the earliest
  // arrival, then the lowest slot, and runs it for one time unit.
  function automatic sched_result_t schedule_request(input sched_req_t r);
    sched_result_t res;
    logic          any_left;
    logic          found;
    int            best;
    int            i;
    res      = '0;
    any_left = 1'b0;
    found    = 1'b0;
    best     = 0;
    if (r.cmd == CMD_LOAD) begin
      if (table_fill >= NPROC) begin
        res.status = ST_FULL;
        n_rejected++;
      end else begin
        tbl_arrival[table_fill] = r.arrival;
        tbl_left[table_fill]    = r.burst;
        tbl_prio[table_fill]    = r.prio;
        res.status              = ST_LOADED;
        res.slot                = table_fill[SLOT_OUT_W-1:0];
        table_fill++;
        n_loaded++;
      end
      return res;
    end

    res.tick_time = clock_units;
    for (i = 0; i < table_fill; i++) begin
      if (tbl_left[i] != '0) begin
        any_left = 1'b1;
        if (tbl_arrival[i] <= clock_units) begin
          if (!found) begin
            found = 1'b1;
            best  = i;
          end else if (tbl_prio[i] > tbl_prio[best]) begin
            best = i;
          end else if (tbl_prio[i] == tbl_prio[best] &&
                       tbl_arrival[i] < tbl_arrival[best]) begin
            best = i;
          end
        end
      end
    end

    // With no work left anywhere the tick is answered but time stands still.
    if (!any_left) begin
      res.status = ST_FINISHED;
      n_finished++;
      return res;
    end

    if (!found) begin
      res.status = ST_IDLE;
      n_idle++;
    end else begin
      tbl_left[best] = tbl_left[best] - 1'b1;
      res.status     = ST_RAN;
      res.slot       = best[SLOT_OUT_W-1:0];
      res.completed  = (tbl_left[best] == '0);
      n_ran++;
      if (res.completed) n_completed++;
    end
    if (clock_units != TIME_MAX) clock_units = clock_units + 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random request shaping
  // --------------------------------------------------------------------------
  // Loads are rare while slots are free, so the table fills over several
  // hundred requests and the processes compete for a long time. Most loads
  // arrive shortly after the current time with modest bursts; half take a
  // narrow band of priorities, giving plenty of ties and preemptions. A burst
  // drawn over the full range comes with an arrival over the full range, so
  // such a process usually stays pending to the end of the run. Once the
  // table is full, a tenth of the requests are loads that must be turned away.
  function automatic sched_req_t random_request();
    sched_req_t r;
    int         roll;
    int         shape;
    int         near;
    r.cmd     = CMD_TICK;
    r.arrival = TIME_W'($urandom);
    r.burst   = TIME_W'($urandom);
    r.prio    = PRI_W'($urandom);
    roll      = $urandom_range(999);
    if (table_fill < NPROC) begin
      if (roll < 18) begin
        r.cmd = CMD_LOAD;
        shape = $urandom_range(9);
        if (shape != 2) begin
          near = int'(clock_units) + $urandom_range(40);
          r.arrival = (near > int'(TIME_MAX)) ? TIME_MAX : near[TIME_W-1:0];
        end
        case (shape)
          0: r.burst = '0;
          1: r.burst = 1;
          2: r.burst = TIME_W'($urandom);
          default: r.burst = TIME_W'($urandom_range(150, 5));
        endcase
        if ($urandom_range(1) == 0) r.prio = PRI_W'($urandom_range(3));
      end
    end else if (roll < 100) begin
      r.cmd = CMD_LOAD;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Entered and left just after a falling edge. Puts one request on the
  // input channel after a random idle gap, holds it until the scheduler
  // takes it, and records the result it owes.
  task automatic issue(input sched_req_t r, input logic known,
                       input sched_result_t typed);
    sched_result_t want;
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= r.cmd;
    in_arrival_time <= r.arrival;
    in_burst_time   <= r.burst;
    in_priority_req <= r.prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = schedule_request(r);
    if (known) want = typed;
    awaited_outcomes.push_back(want);
    @(negedge clk);
  endtask

  // Adds one row to the directed table.
  task automatic plan(input logic cmd, input logic [TIME_W-1:0] arrival,
                      input logic [TIME_W-1:0] burst, input logic [PRI_W-1:0] prio,
                      input logic known, input status_t st,
                      input logic [SLOT_OUT_W-1:0] slot, input logic done,
                      input logic [TIME_W-1:0] tick_time);
    plan_row_t row;
    row.req.cmd        = cmd;
    row.req.arrival    = arrival;
    row.req.burst      = burst;
    row.req.prio       = prio;
    row.known          = known;
    row.want.status    = st;
    row.want.slot      = slot;
    row.want.completed = done;
    row.want.tick_time = tick_time;
    directed_plan.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 40)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // The receiver stalls at random, except in the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 35);
  end

  // Every result taken off the channel is matched against the oldest one
  // that is still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch("unrequested result, status", out_status, '0);
      end else begin
        head = awaited_outcomes.pop_front();
        if (out_status !== head.status)
          flag_mismatch("status", out_status, head.status);
        if (out_slot !== head.slot)
          flag_mismatch("slot", out_slot, head.slot);
        if (out_completed !== head.completed)
          flag_mismatch("completed", out_completed, head.completed);
        if (out_tick_time !== head.tick_time)
          flag_mismatch("tick_time", out_tick_time, head.tick_time);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         k;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = CMD_LOAD;
    in_arrival_time = '0;
    in_burst_time   = '0;
    in_priority_req = '0;
    quiet           = 1'b0;
    table_fill      = 0;
    clock_units     = '0;
    n_loaded = 0; n_rejected = 0; n_ran = 0;
    n_idle = 0; n_finished = 0; n_completed = 0;

    // Directed table. Loads, and ticks whose answer follows directly from
    // the table so far, carry their expected result; the ticks where the
    // choice among several candidates matters are left to the predictor.
    // A tick on an empty table has nothing left to run.
    plan(CMD_TICK, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_FINISHED, 0, 1'b0, 0);
    plan(CMD_LOAD, 16'h0000, 16'h0000, 8'h00, 1'b1, ST_LOADED,   0, 1'b0, 0);
    // A process with a zero burst counts as finished already; the tick's own
    // payload fields are all ones and must be ignored.
    plan(CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, ST_FINISHED, 0, 1'b0, 0);
    // Top priority arriving at time 3: three idle ticks, then two runs.
    plan(CMD_LOAD, 16'd3, 16'd2, 8'hFF, 1'b1, ST_LOADED,   1, 1'b0, 0);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_IDLE,     0, 1'b0, 0);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_IDLE,     0, 1'b0, 1);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_IDLE,     0, 1'b0, 2);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_RAN,      1, 1'b0, 3);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_RAN,      1, 1'b1, 4);
    plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b1, ST_FINISHED, 0, 1'b0, 5);
    // Slots 2 and 3 tie exactly; slot 4 has the same priority and arrived
    // earlier, so it must win despite its higher slot.
    plan(CMD_LOAD, 16'd4, 16'd2, 8'd9, 1'b1, ST_LOADED, 2, 1'b0, 0);
    plan(CMD_LOAD, 16'd4, 16'd1, 8'd9, 1'b1, ST_LOADED, 3, 1'b0, 0);
    plan(CMD_LOAD, 16'd1, 16'd1, 8'd9, 1'b1, ST_LOADED, 4, 1'b0, 0);
    for (k = 0; k < 3; k++)
      plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b0, ST_RAN, 0, 1'b0, 0);
    // Lowest priority, arrived long ago, waits for everyone else.
    plan(CMD_LOAD, 16'd0, 16'd1, 8'h00, 1'b1, ST_LOADED, 5, 1'b0, 0);
    for (k = 0; k < 4; k++)
      plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b0, ST_RAN, 0, 1'b0, 0);
    // All fields at their maximum: arrives only once time saturates, and
    // keeps work pending for the rest of the run.
    plan(CMD_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, ST_LOADED, 6, 1'b0, 0);
    for (k = 0; k < 2; k++)
      plan(CMD_TICK, 16'd0, 16'd0, 8'h00, 1'b0, ST_RAN, 0, 1'b0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      issue(directed_plan[i].req, directed_plan[i].known, directed_plan[i].want);

    // Random traffic, with one stretch free of idling on both sides.
    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      quiet = (k >= QUIET_FROM && k < QUIET_TO);
      issue(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (NPROC + 6) @(posedge clk);

    $display("Covered %0d loads, %0d loads turned away on a full table, %0d ticks run",
             n_loaded, n_rejected, n_ran);
    $display("(%0d completions), %0d idle ticks, %0d ticks with all work done; time at %0d",
             n_completed, n_idle, n_finished, clock_units);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
